[hw/rtl/ppfr_pkg.sv]
// shared constants, types and helpers of the pixel packet frame ring
`default_nettype none
package ppfr_pkg;

    localparam int PIXELS       = 800;
    localparam int SLOTS        = 6;
    localparam int CHANNELS     = 4;
    localparam int HEADER_BYTES = 6;

    localparam int GROUP_RAW = CHANNELS;
    localparam int GROUP_RLE = CHANNELS + 1;

    localparam logic [9:0] PIXELS_W = 10'(PIXELS);
    localparam logic [2:0] SLOTS_W  = 3'(SLOTS);

    typedef logic [2:0] slot_t;

    localparam logic [1:0] KIND_RUN     = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [1:0] PHASE_NEW      = 2'd0;
    localparam logic [1:0] PHASE_PROGRESS = 2'd1;
    localparam logic [1:0] PHASE_COMPLETE = 2'd2;

    localparam logic [2:0] POS_CMD  = 3'd0;
    localparam logic [2:0] POS_FMT  = 3'd1;
    localparam logic [2:0] POS_HI   = 3'(HEADER_BYTES - 2);
    localparam logic [2:0] POS_LO   = 3'(HEADER_BYTES - 1);
    localparam logic [2:0] POS_DATA = 3'(HEADER_BYTES);
    localparam logic [2:0] POS_IDLE = 3'd7;

    localparam logic [7:0] CMD_NEW  = 8'd0;
    localparam logic [7:0] CMD_CONT = 8'd1;
    localparam logic [7:0] FMT_RAW  = 8'd0;
    localparam logic [7:0] FMT_RLE  = 8'd1;

    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_EARLY_DEPTH  = 1'b1;

    typedef struct packed {
        logic       tick;
        logic [7:0] data;
        logic       first;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        slot_t      slot;
        logic [9:0] start_pixel;
        logic [7:0] run_length;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
        logic [9:0] frame_length;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic slot_t next_slot(slot_t s);
        return (s == SLOTS_W - 3'd1) ? 3'd0 : s + 3'd1;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ppfr_front.sv]
// input queue that takes requests and tags each as a tick or a packet byte
`default_nettype none
module ppfr_front
    import ppfr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  in_opcode,
    input  wire logic  [7:0] in_data,
    input  wire logic  in_first,
    input  wire logic  in_last,
    output logic       item_valid,
    input  wire logic  item_ready,
    output item_t      item
);

    item_t      ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push, pop;

    assign in_ready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = ent_reg[rd_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= '{tick: in_opcode, data: in_data, first: in_first,
                                 last: in_last};
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ppfr_back.sv]
// packet parser, run decoder and frame ring control
`default_nettype none
module ppfr_back
    import ppfr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  cfg_wr_en,
    input  wire logic  cfg_index,
    input  wire logic  [23:0] cfg_wr_data,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  item_t      item,
    input  wire logic  room,
    output push_t      push
);

    logic [23:0] min_interval_reg;
    logic [2:0]  early_depth_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] target_reg, target_next;
    logic [9:0]  cursor_reg, cursor_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  format_reg, format_next;
    logic [7:0]  command_reg, command_next;
    logic        dropped_reg, dropped_next;
    logic [39:0] group_reg, group_next;
    logic [2:0]  fill_reg, fill_next;
    slot_t       front_reg, front_next;
    slot_t       back_reg, back_next;
    logic [2:0]  buffered_reg, buffered_next;
    logic [23:0] elapsed_reg, elapsed_next;
    logic [9:0]  slot_length [SLOTS];

    logic        accept;
    logic        len_we;
    logic [9:0]  len_val;
    logic [15:0] value;
    logic [9:0]  lim, rem;
    logic [7:0]  count, run;
    logic [2:0]  gsize;
    logic        run_ok;
    result_t     r0, r1;
    logic [1:0]  n;

    assign item_ready = room;
    assign accept     = item_valid && room;

    always_comb begin
        phase_next    = phase_reg;
        target_next   = target_reg;
        cursor_next   = cursor_reg;
        pos_next      = pos_reg;
        hold_next     = hold_reg;
        format_next   = format_reg;
        command_next  = command_reg;
        dropped_next  = dropped_reg;
        group_next    = group_reg;
        fill_next     = fill_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        buffered_next = buffered_reg;
        elapsed_next  = elapsed_reg;
        len_we  = 1'b0;
        len_val = '0;
        value   = '0;
        lim     = '0;
        rem     = '0;
        count   = '0;
        run     = '0;
        run_ok  = 1'b0;
        gsize   = (format_reg == FMT_RLE) ? 3'(GROUP_RLE) : 3'(GROUP_RAW);
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        if (item.tick) begin
            if (elapsed_reg != 24'hFFFFFF) elapsed_next = elapsed_reg + 24'd1;
            if (buffered_reg != 3'd0 && !(elapsed_next < min_interval_reg &&
                                         buffered_reg < early_depth_reg)) begin
                r0.kind         = KIND_RELEASE;
                r0.slot         = front_reg;
                r0.frame_length = slot_length[front_reg];
                n               = 2'd1;
                front_next      = next_slot(front_reg);
                buffered_next   = buffered_reg - 3'd1;
                elapsed_next    = '0;
            end
        end else if (item.first || pos_reg != POS_IDLE) begin
            if (item.first) begin
                pos_next     = POS_CMD;
                dropped_next = 1'b0;
                fill_next    = '0;
                group_next   = '0;
            end
            if (pos_next != POS_DATA) begin
                if (pos_next == POS_CMD) command_next = item.data;
                if (pos_next == POS_FMT) format_next = item.data;
                if (pos_next == POS_HI) hold_next = item.data;
                if (pos_next == POS_LO) begin
                    value      = {hold_reg, item.data};
                    fill_next  = '0;
                    group_next = '0;
                    if (command_next == CMD_NEW ||
                        (command_next == CMD_CONT && phase_reg == PHASE_PROGRESS)) begin
                        if (command_next == CMD_NEW) begin
                            cursor_next = '0;
                            target_next = value;
                        end else begin
                            cursor_next = (value < 16'(PIXELS)) ? value[9:0] : PIXELS_W;
                        end
                        if (buffered_reg >= SLOTS_W) begin
                            phase_next   = PHASE_COMPLETE;
                            dropped_next = 1'b1;
                        end else begin
                            phase_next = PHASE_PROGRESS;
                        end
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
                pos_next = pos_next + 3'd1;
            end else if (!dropped_next && format_reg <= FMT_RLE) begin
                group_next = {group_next[31:0], item.data};
                fill_next  = fill_next + 3'd1;
                if (fill_next >= gsize) begin
                    fill_next = '0;
                    lim = (target_reg < 16'(PIXELS)) ? target_reg[9:0] : PIXELS_W;
                    if (cursor_reg < lim) begin
                        rem   = lim - cursor_reg;
                        count = (format_reg == FMT_RLE) ?
                                group_next[8*GROUP_RLE-1 -: 8] : 8'd1;
                        run   = ({2'b00, count} > rem) ? rem[7:0] : count;
                        run_ok = (run != 8'd0);
                    end
                    if (run_ok) begin
                        r0.kind        = KIND_RUN;
                        r0.slot        = back_reg;
                        r0.start_pixel = cursor_reg;
                        r0.run_length  = run;
                        r0.green       = group_next[8*CHANNELS-1 -: 8];
                        r0.red         = group_next[8*CHANNELS-9 -: 8];
                        r0.blue        = group_next[8*CHANNELS-17 -: 8];
                        r0.white       = (CHANNELS >= 4) ? group_next[7:0] : 8'd0;
                        n              = 2'd1;
                        cursor_next    = cursor_reg + {2'b00, run};
                    end
                end
            end
            if (item.last) begin
                if (pos_next == POS_DATA && !dropped_next &&
                    ({6'd0, cursor_next} == target_next || cursor_next == PIXELS_W) &&
                    buffered_reg < SLOTS_W) begin
                    len_val = (target_next < 16'(PIXELS)) ? target_next[9:0] : PIXELS_W;
                    len_we  = 1'b1;
                    r1 = '0;
                    r1.kind         = KIND_DONE;
                    r1.slot         = back_reg;
                    r1.frame_length = len_val;
                    if (n == 2'd0) r0 = r1;
                    n             = n + 2'd1;
                    back_next     = next_slot(back_reg);
                    buffered_next = buffered_reg + 3'd1;
                    phase_next    = PHASE_COMPLETE;
                end
                pos_next = POS_IDLE;
            end
        end
        if (n == 2'd1) r0.last = 1'b1;
        if (n == 2'd2) r1.last = 1'b1;
    end

    assign push = '{count: accept ? n : 2'd0, res0: r0, res1: r1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg <= 24'd36000;
            early_depth_reg  <= 3'd5;
            phase_reg    <= PHASE_COMPLETE;
            target_reg   <= '0;
            cursor_reg   <= '0;
            pos_reg      <= POS_CMD;
            hold_reg     <= '0;
            format_reg   <= '0;
            command_reg  <= '0;
            dropped_reg  <= 1'b0;
            group_reg    <= '0;
            fill_reg     <= '0;
            front_reg    <= '0;
            back_reg     <= '0;
            buffered_reg <= '0;
            elapsed_reg  <= '0;
        end else begin
            if (cfg_wr_en && cfg_index == REG_MIN_INTERVAL) min_interval_reg <= cfg_wr_data;
            if (cfg_wr_en && cfg_index == REG_EARLY_DEPTH) early_depth_reg <= cfg_wr_data[2:0];
            if (accept) begin
                phase_reg    <= phase_next;
                target_reg   <= target_next;
                cursor_reg   <= cursor_next;
                pos_reg      <= pos_next;
                hold_reg     <= hold_next;
                format_reg   <= format_next;
                command_reg  <= command_next;
                dropped_reg  <= dropped_next;
                group_reg    <= group_next;
                fill_reg     <= fill_next;
                front_reg    <= front_next;
                back_reg     <= back_next;
                buffered_reg <= buffered_next;
                elapsed_reg  <= elapsed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && len_we) slot_length[back_reg] <= len_val;
    end

endmodule
`default_nettype wire

[hw/rtl/ppfr_outq.sv]
// result queue taking up to two results a cycle with room, giving one while ready
`default_nettype none
module ppfr_outq
    import ppfr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  push_t      push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    result_t    ent_reg [4];
    logic [2:0] cnt_reg;
    logic [1:0] rd_reg, wr_reg;
    logic       pop;

    assign room      = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_res   = ent_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
            wr_reg  <= '0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push.count} - {2'b00, pop};
            wr_reg  <= wr_reg + push.count;
            if (pop) rd_reg <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) ent_reg[wr_reg] <= push.res0;
        if (push.count == 2'd2) ent_reg[wr_reg + 2'd1] <= push.res1;
    end

endmodule
`default_nettype wire

[hw/rtl/pixel_packet_frame_ring.sv]
// top level of the pixel packet frame ring
//
// channel  | ports        | tdata / tuser
// input    | s_axis_*     | byte and first mark / opcode, tlast is last byte
// result   | m_axis_*     | run, colour and length / kind, tlast is last result
// config   | cfg_*        | index 0 interval, index 1 early release depth
//
// one request is taken per cycle while there is room; two results go out separately
// two-entry input queue, four-entry result queue set the stall decoupling
// the parser accepts while at least two result places are free
// reset is synchronous and active low; no clearing pass after reset
`default_nettype none
module pixel_packet_frame_ring
    import ppfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // data_byte, first_byte
    input  wire logic        s_axis_tuser,  // opcode
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // slot, start_pixel, run_length, red, green,
                                            // blue, white, frame_length
    output logic [1:0]       m_axis_tuser,  // kind
    output logic             m_axis_tlast
);

    item_t   item;
    logic    item_valid, item_ready, room;
    push_t   push;
    result_t res;

    ppfr_front u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_opcode(s_axis_tuser), .in_data(s_axis_tdata[7:0]),
        .in_first(s_axis_tdata[8]), .in_last(s_axis_tlast),
        .item_valid, .item_ready, .item
    );

    ppfr_back u_back (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .item_valid, .item_ready, .item, .room, .push
    );

    ppfr_outq u_outq (
        .aclk, .aresetn, .push, .room,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {1'b0, res.frame_length, res.white, res.blue, res.green,
                           res.red, res.run_length, res.start_pixel, res.slot};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

[hw/rtl/ppfr_checker.sv]
// port checker for the pixel packet frame ring and its bind
`default_nettype none
module ppfr_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_run_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == 2'd0 |->
        m_axis_tdata[20:13] != 8'd0 && m_axis_tdata[62:53] == 10'd0)
        else $error("bad run write");

    a_frame_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != 2'd0 |->
        m_axis_tuser != 2'd3 && m_axis_tdata[52:3] == 50'd0 && m_axis_tlast)
        else $error("bad frame result");

endmodule

bind pixel_packet_frame_ring ppfr_port_checker u_ppfr_port_checker (.*);
`default_nettype wire

[dv/ppfr_checker.sv]
// checker of the pixel packet frame ring: watches both channels, predicts results and compares
module ppfr_checker
    import ppfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    result_t     ring_results_q[$];
    result_t     step_q[$];

    logic [23:0] interval;
    logic [2:0]  depth;
    logic [1:0]  phase;
    logic [15:0] target;
    int          cursor;
    logic [2:0]  bpos;
    logic [15:0] hold;
    logic [7:0]  cmd;
    logic [7:0]  fmt;
    logic        dropped;
    logic [39:0] grp;
    int          fill;
    slot_t       front;
    slot_t       back;
    int          buffered;
    logic [9:0]  lens[SLOTS];
    logic [23:0] elapsed;

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic int frame_limit();
        return (int'(target) < PIXELS) ? int'(target) : PIXELS;
    endfunction

    task automatic add_result(logic [1:0] kind, slot_t s, int start, int run,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] w, int flen);
        result_t res;
        res.kind = kind;
        res.slot = s;
        res.start_pixel = 10'(start);
        res.run_length = 8'(run);
        res.red = r;
        res.green = g;
        res.blue = b;
        res.white = w;
        res.frame_length = 10'(flen);
        res.last = 1'b0;
        step_q.push_back(res);
    endtask

    task automatic open_data();
        if (buffered >= SLOTS) begin
            phase = PHASE_COMPLETE;
            dropped = 1'b1;
        end else begin
            phase = PHASE_PROGRESS;
        end
    endtask

    task automatic decode_pixels(logic [7:0] b);
        int size;
        int lim;
        int run;
        logic rle;
        rle = (fmt == FMT_RLE);
        size = rle ? GROUP_RLE : GROUP_RAW;
        if (fmt > FMT_RLE) return;
        grp = {grp[31:0], b};
        fill++;
        if (fill < size) return;
        fill = 0;
        lim = frame_limit();
        if (cursor >= lim) return;
        run = rle ? int'(grp[8*GROUP_RLE-1 -: 8]) : 1;
        if (run > lim - cursor) run = lim - cursor;
        if (run == 0) return;
        add_result(KIND_RUN, back, cursor, run, grp[8*CHANNELS-9 -: 8],
                   grp[8*CHANNELS-1 -: 8], grp[8*CHANNELS-17 -: 8],
                   (CHANNELS >= 4) ? grp[7:0] : 8'd0, 0);
        cursor += run;
    endtask

    task automatic complete_frame();
        int len;
        if (cursor != int'(target) && cursor != PIXELS) return;
        if (buffered >= SLOTS || back >= SLOTS_W) return;
        len = frame_limit();
        lens[back] = 10'(len);
        add_result(KIND_DONE, back, 0, 0, 0, 0, 0, 0, len);
        back = next_slot(back);
        buffered++;
        phase = PHASE_COMPLETE;
    endtask

    task automatic predict_item(logic tick, logic [7:0] b, logic first, logic lastb);
        step_q.delete();
        if (tick) begin
            if (elapsed != 24'hFFFFFF) elapsed++;
            if (buffered != 0 && front < SLOTS_W &&
                !(elapsed < interval && buffered < int'(depth))) begin
                add_result(KIND_RELEASE, front, 0, 0, 0, 0, 0, 0, int'(lens[front]));
                front = next_slot(front);
                buffered--;
                elapsed = '0;
            end
        end else if (first || bpos != POS_IDLE) begin
            if (first) begin
                bpos = POS_CMD;
                dropped = 1'b0;
                fill = 0;
                grp = '0;
            end
            if (bpos < POS_DATA) begin
                if (bpos == POS_CMD) cmd = b;
                else if (bpos == POS_FMT) fmt = b;
                else if (bpos == POS_HI) hold = {b, 8'd0};
                if (bpos == POS_LO) begin
                    hold = hold | {8'd0, b};
                    fill = 0;
                    grp = '0;
                    if (cmd == CMD_NEW) begin
                        phase = PHASE_NEW;
                        cursor = 0;
                        target = hold;
                        open_data();
                    end else if (cmd == CMD_CONT && phase == PHASE_PROGRESS) begin
                        cursor = (int'(hold) < PIXELS) ? int'(hold) : PIXELS;
                        open_data();
                    end else begin
                        dropped = 1'b1;
                    end
                end
                bpos++;
            end else if (!dropped) begin
                decode_pixels(b);
            end
            if (lastb) begin
                if (bpos == POS_DATA && !dropped) complete_frame();
                bpos = POS_IDLE;
            end
        end
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) ring_results_q.push_back(step_q[i]);
    endtask

    task automatic compare_result();
        result_t want;
        if (ring_results_q.size() == 0) begin
            report("result with none expected, kind", m_axis_tuser, 0);
            return;
        end
        want = ring_results_q.pop_front();
        if (m_axis_tuser != want.kind) report("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[2:0] != want.slot) report("slot", m_axis_tdata[2:0], want.slot);
        if (m_axis_tdata[12:3] != want.start_pixel)
            report("start_pixel", m_axis_tdata[12:3], want.start_pixel);
        if (m_axis_tdata[20:13] != want.run_length)
            report("run_length", m_axis_tdata[20:13], want.run_length);
        if (m_axis_tdata[28:21] != want.red) report("red", m_axis_tdata[28:21], want.red);
        if (m_axis_tdata[36:29] != want.green)
            report("green", m_axis_tdata[36:29], want.green);
        if (m_axis_tdata[44:37] != want.blue) report("blue", m_axis_tdata[44:37], want.blue);
        if (m_axis_tdata[52:45] != want.white)
            report("white", m_axis_tdata[52:45], want.white);
        if (m_axis_tdata[62:53] != want.frame_length)
            report("frame_length", m_axis_tdata[62:53], want.frame_length);
        if (m_axis_tdata[63] != 1'b0) report("tdata pad", m_axis_tdata[63], 0);
        if (m_axis_tlast != want.last) report("last", m_axis_tlast, want.last);
    endtask

    initial begin
        errors = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            interval = 24'd36000;
            depth = 3'd5;
            phase = PHASE_COMPLETE;
            target = '0;
            cursor = 0;
            bpos = POS_CMD;
            hold = '0;
            cmd = '0;
            fmt = '0;
            dropped = 1'b0;
            grp = '0;
            fill = 0;
            front = '0;
            back = '0;
            buffered = 0;
            elapsed = '0;
            foreach (lens[i]) lens[i] = '0;
            ring_results_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_MIN_INTERVAL) interval = cfg_wr_data;
                else depth = cfg_wr_data[2:0];
            end
            if (m_axis_tvalid && m_axis_tready) compare_result();
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8], s_axis_tlast);
        end
        pending = ring_results_q.size();
    end

endmodule

[dv/testbench.sv]
// top of the pixel packet frame ring testbench: clock, reset, stimulus and verdict
module testbench;
    import ppfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [23:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          errors;
    int          pending;

    int          sent;
    logic        burst;
    logic [7:0]  payload_q[$];

    pixel_packet_frame_ring uut (.*);

    ppfr_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("pixel_packet_frame_ring regression: fail");
        $finish;
    end

    // result side stalls
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(logic tick, logic [7:0] b, logic first, logic lastb);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, first, b};
        s_axis_tuser <= tick;
        s_axis_tlast <= lastb;
        do @(posedge aclk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
    endtask

    task automatic send_packet(logic [7:0] c, logic [7:0] f, logic [15:0] value);
        logic [7:0] hdr[6];
        hdr = '{c, f, 8'($urandom), 8'($urandom), value[15:8], value[7:0]};
        for (int i = 0; i < 6; i++)
            send_item(1'b0, hdr[i], i == 0, (i == 5) && payload_q.size() == 0);
        foreach (payload_q[i])
            send_item(1'b0, payload_q[i], 1'b0, i == payload_q.size() - 1);
    endtask

    // groups of pixels, an rle count first when asked, then any extra bytes
    task automatic fill_payload(logic rle, int groups, int max_run, int extra);
        payload_q.delete();
        repeat (groups) begin
            if (rle) payload_q.push_back(8'($urandom_range(0, max_run)));
            repeat (CHANNELS) payload_q.push_back(8'($urandom));
        end
        repeat (extra) payload_q.push_back(8'($urandom));
    endtask

    task automatic write_regs(logic [23:0] interval, logic [23:0] depth);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MIN_INTERVAL;
        cfg_wr_data <= interval;
        @(posedge aclk);
        cfg_index <= REG_EARLY_DEPTH;
        cfg_wr_data <= depth;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic random_request_mix(int quota);
        int pick;
        int n;
        int k;
        logic rle;
        while (sent < quota) begin
            burst = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            rle = 1'($urandom_range(0, 1));
            if (pick < 45) begin
                n = $urandom_range(1, 12);
                fill_payload(rle, rle ? $urandom_range(1, 5) : n + $urandom_range(0, 1) - 1,
                             8, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
                send_packet(CMD_NEW, rle ? FMT_RLE : FMT_RAW, 16'(n));
            end else if (pick < 60) begin
                n = $urandom_range(2, 12);
                k = $urandom_range(1, n - 1);
                fill_payload(1'b0, k, 0, 0);
                send_packet(CMD_NEW, FMT_RAW, 16'(n));
                if ($urandom_range(0, 3) == 0) send_ticks(1);
                fill_payload(1'b0, n - k, 0, 0);
                send_packet(CMD_CONT, FMT_RAW, 16'(k));
            end else if (pick < 68) begin
                fill_payload(rle, $urandom_range(0, 3), 255, 0);
                send_packet(CMD_CONT, rle ? FMT_RLE : FMT_RAW,
                            ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                          16'($urandom_range(0, 20)));
            end else if (pick < 76) begin
                fill_payload(rle, $urandom_range(0, 3), 255, $urandom_range(0, 2));
                send_packet(8'($urandom_range(0, 3)), 8'($urandom), 16'($urandom_range(0, 15)));
            end else if (pick < 82) begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_item(1'b0, 8'($urandom), i == 0, i == n - 1);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 3))
                    send_item(1'b0, 8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
            end else if (pick < 94) begin
                n = $urandom_range(2, 9);
                for (int i = 0; i < n; i++)
                    send_item(1'b0, (i == 0) ? CMD_NEW : 8'($urandom), i == 0, 1'b0);
            end else begin
                fill_payload(1'b1, 4, 255, 0);
                foreach (payload_q[i]) if (i % GROUP_RLE == 0) payload_q[i] = 8'd255;
                send_packet(CMD_NEW, FMT_RLE,
                            ($urandom_range(0, 1) == 0) ? 16'($urandom_range(700, 1023)) : 16'hFFFF);
            end
            send_ticks($urandom_range(0, 5));
        end
    endtask

    initial begin
        logic [23:0] intervals[6];
        logic [23:0] depths[6];
        intervals = '{24'd0, 24'd4, 24'hFFFFFF, 24'd20, 24'd100, 24'd2};
        depths = '{24'd1, 24'd3, 24'd6, 24'd0, 24'd7, 24'd2};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MIN_INTERVAL;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        sent = 0;
        burst = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // an unmarked byte straight after reset opens a packet
        send_item(1'b0, CMD_NEW, 1'b0, 1'b0);
        send_item(1'b0, 8'd0, 1'b0, 1'b1);
        send_item(1'b0, 8'hFF, 1'b0, 1'b1);
        fill_payload(1'b0, 1, 0, 2);
        send_packet(CMD_NEW, FMT_RAW, 16'd1);
        payload_q = '{8'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'd255, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                      8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd255, 8'd5, 8'd6, 8'd7, 8'd8,
                      8'd255, 8'd9, 8'd9, 8'd9, 8'd9};
        send_packet(CMD_NEW, FMT_RLE, 16'd1000);
        fill_payload(1'b0, 1, 0, 0);
        send_packet(CMD_CONT, FMT_RAW, 16'd5);
        send_packet(8'd7, FMT_RAW, 16'd1);
        send_packet(CMD_NEW, 8'd9, 16'd0);
        send_ticks(3);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_regs(intervals[p], depths[p]);
            random_request_mix(40 + (p + 1) * 130);
            drain();
            send_ticks(12);
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("pixel_packet_frame_ring regression: pass");
        end else begin
            $display("pixel_packet_frame_ring regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/ppfr_pkg.sv
hw/rtl/ppfr_front.sv
hw/rtl/ppfr_back.sv
hw/rtl/ppfr_outq.sv
hw/rtl/pixel_packet_frame_ring.sv
hw/rtl/ppfr_checker.sv
dv/ppfr_checker.sv
dv/testbench.sv
